@@ design/dtpw_pkg.sv @@
// dtpw_pkg: shared types and constants for the depth-tested pixel write unit
// holds function, status, depth-mode and register codes, the config struct and
// the controller/datapath command and status structs; depends on nothing
`default_nettype none

package dtpw_pkg;

    // input function codes
    localparam logic [1:0] FUNC_DEPTH_WRITE = 2'd0;
    localparam logic [1:0] FUNC_COLOR_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ        = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_DONE     = 2'd0;
    localparam logic [1:0] STAT_CLIPPED  = 2'd1;
    localparam logic [1:0] STAT_REJECTED = 2'd2;

    // depth compare modes
    localparam logic [2:0] DM_ALWAYS        = 3'd0;
    localparam logic [2:0] DM_LESS          = 3'd1;
    localparam logic [2:0] DM_LESS_EQUAL    = 3'd2;
    localparam logic [2:0] DM_GREATER_EQUAL = 3'd3;
    localparam logic [2:0] DM_GREATER       = 3'd4;
    localparam logic [2:0] DM_NOT_EQUAL     = 3'd5;
    localparam logic [2:0] DM_EQUAL         = 3'd6;

    // register indexes (byte address is four times the index)
    localparam logic [2:0] REG_CLIP_WIDTH   = 3'd0;
    localparam logic [2:0] REG_CLIP_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_ROW_STRIDE   = 3'd2;
    localparam logic [2:0] REG_DEPTH_MODE   = 3'd3;
    localparam logic [2:0] REG_DEPTH_ENABLE = 3'd4;

    localparam int PADDR_W = 5;

    // register reset values
    localparam logic [9:0] RST_CLIP_WIDTH   = 10'd320;
    localparam logic [8:0] RST_CLIP_HEIGHT  = 9'd224;
    localparam logic [9:0] RST_ROW_STRIDE   = 10'd512;
    localparam logic [2:0] RST_DEPTH_MODE   = DM_GREATER_EQUAL;
    localparam logic       RST_DEPTH_ENABLE = 1'b1;

    // value held by every depth word after reset
    localparam logic [31:0] DEPTH_MIN = 32'h8000_0000;

    // width of the linear address sum: 9-bit row times 11-bit stride plus 10-bit column
    localparam int SUM_W = 21;

    typedef struct packed {
        logic [9:0] clip_width;
        logic [8:0] clip_height;
        logic [9:0] row_stride;
        logic [2:0] depth_mode;
        logic       depth_enable;
    } t_cfg;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_ADDR  = 5'b00100,
        S_READ  = 5'b01000,
        S_TEST  = 5'b10000
    } t_state;

    typedef struct packed {
        logic clr_en;
        logic load_in;
        logic calc_addr;
        logic rd_en;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
    } t_sts;

endpackage

`default_nettype wire

@@ design/dtpw_in_if.sv @@
// dtpw_in_if: valid/ready channel carrying one pixel item into the unit
// standalone interface, no dependencies
`default_nettype none

interface dtpw_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [31:0] pixel_x;
    logic signed [31:0] pixel_y;
    logic signed [31:0] pixel_depth;
    logic [15:0]        pixel_color;

    modport source (
        output valid, func, pixel_x, pixel_y, pixel_depth, pixel_color,
        input  ready
    );

    modport sink (
        input  valid, func, pixel_x, pixel_y, pixel_depth, pixel_color,
        output ready
    );
endinterface

`default_nettype wire

@@ design/dtpw_out_if.sv @@
// dtpw_out_if: valid/ready channel carrying one result item out of the unit
// standalone interface, no dependencies
`default_nettype none

interface dtpw_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [15:0]        read_color;
    logic signed [31:0] read_depth;

    modport source (
        output valid, status, read_color, read_depth,
        input  ready
    );

    modport sink (
        input  valid, status, read_color, read_depth,
        output ready
    );
endinterface

`default_nettype wire

@@ design/dtpw_cfg.sv @@
// dtpw_cfg: apb-style configuration registers of the pixel write unit
// depends on dtpw_pkg for register indexes, reset values and t_cfg
`default_nettype none

module dtpw_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dtpw_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output dtpw_pkg::t_cfg                o_cfg
);
    import dtpw_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_width   <= RST_CLIP_WIDTH;
            r_cfg.clip_height  <= RST_CLIP_HEIGHT;
            r_cfg.row_stride   <= RST_ROW_STRIDE;
            r_cfg.depth_mode   <= RST_DEPTH_MODE;
            r_cfg.depth_enable <= RST_DEPTH_ENABLE;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CLIP_WIDTH:   r_cfg.clip_width   <= pwdata[9:0];
                REG_CLIP_HEIGHT:  r_cfg.clip_height  <= pwdata[8:0];
                REG_ROW_STRIDE:   r_cfg.row_stride   <= pwdata[9:0];
                REG_DEPTH_MODE:   r_cfg.depth_mode   <= pwdata[2:0];
                REG_DEPTH_ENABLE: r_cfg.depth_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CLIP_WIDTH:   prdata = {22'd0, r_cfg.clip_width};
            REG_CLIP_HEIGHT:  prdata = {23'd0, r_cfg.clip_height};
            REG_ROW_STRIDE:   prdata = {22'd0, r_cfg.row_stride};
            REG_DEPTH_MODE:   prdata = {29'd0, r_cfg.depth_mode};
            REG_DEPTH_ENABLE: prdata = {31'd0, r_cfg.depth_enable};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ design/dtpw_ctrl.sv @@
// dtpw_ctrl: sequencing state machine of the pixel write unit
// depends on dtpw_pkg for t_state, t_cmd and t_sts; drives the datapath by commands
`default_nettype none

module dtpw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  dtpw_pkg::t_sts i_sts,
    output dtpw_pkg::t_cmd o_cmd
);
    import dtpw_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;
    logic   slot_free;

    // output register can take a result when empty or being drained this cycle
    assign slot_free = ~r_out_valid | i_out_ready;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = S_ADDR;
                end
            end
            S_ADDR: begin
                cmd.calc_addr = 1'b1;
                n_state       = S_READ;
            end
            S_READ: begin
                cmd.rd_en = 1'b1;
                n_state   = S_TEST;
            end
            S_TEST: begin
                if (slot_free) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

@@ design/dtpw_dp.sv @@
// dtpw_dp: datapath of the pixel write unit: address, clipping, colour and
// depth stores, depth test and result register; depends on dtpw_pkg
`default_nettype none

module dtpw_dp #(
    parameter int STORE_WORDS = 131072,
    parameter int MAX_ROW     = 512,
    parameter int MAX_LINES   = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dtpw_pkg::t_cfg     i_cfg,
    input  dtpw_pkg::t_cmd     i_cmd,
    output dtpw_pkg::t_sts     o_sts,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_pixel_x,
    input  logic signed [31:0] i_pixel_y,
    input  logic signed [31:0] i_pixel_depth,
    input  logic [15:0]        i_pixel_color,
    output logic [1:0]         o_status,
    output logic [15:0]        o_read_color,
    output logic signed [31:0] o_read_depth
);
    import dtpw_pkg::*;

    localparam int ADDR_W = $clog2(STORE_WORDS);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(STORE_WORDS - 1);
    localparam logic [10:0]       ROW_LIM    = 11'(MAX_ROW);
    localparam logic [9:0]        LINE_LIM   = 10'(MAX_LINES);
    localparam logic [SUM_W-1:0]  STORE_LIM  = SUM_W'(STORE_WORDS);

    logic [15:0] color_mem [STORE_WORDS];
    logic [31:0] depth_mem [STORE_WORDS];

    // captured item
    logic [1:0]  r_func;
    logic [15:0] r_ix;
    logic [15:0] r_iy;
    logic [31:0] r_depth;
    logic [15:0] r_color;

    logic              r_clip;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_clr_cnt;
    logic [15:0]       r_rd_color;
    logic [31:0]       r_rd_depth;

    logic [1:0]  r_status;
    logic [15:0] r_read_color;
    logic [31:0] r_read_depth;

    logic [10:0]       lim_w;
    logic [10:0]       lim_stride;
    logic [9:0]        lim_h;
    logic [SUM_W-1:0]  addr_sum;
    logic              clip;

    logic              is_read;
    logic              color_only;
    logic              pass;
    logic              wr_color;
    logic              wr_depth;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_color_data;
    logic [31:0]       wr_depth_data;

    function automatic logic depth_pass(input logic [2:0] mode,
                                        input logic [31:0] fresh,
                                        input logic [31:0] held);
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               res;
        a = fresh;
        b = held;
        case (mode)
            DM_LESS:          res = (a <  b);
            DM_LESS_EQUAL:    res = (a <= b);
            DM_GREATER_EQUAL: res = (a >= b);
            DM_GREATER:       res = (a >  b);
            DM_NOT_EQUAL:     res = (a != b);
            DM_EQUAL:         res = (a == b);
            default:          res = 1'b1;
        endcase
        return res;
    endfunction

    // oversized registers saturate to the largest row and line counts
    assign lim_w      = ({1'b0, i_cfg.clip_width} > ROW_LIM) ? ROW_LIM
                                                               : {1'b0, i_cfg.clip_width};
    assign lim_stride = ({1'b0, i_cfg.row_stride} > ROW_LIM) ? ROW_LIM
                                                               : {1'b0, i_cfg.row_stride};
    assign lim_h      = ({1'b0, i_cfg.clip_height} > LINE_LIM) ? LINE_LIM
                                                                 : {1'b0, i_cfg.clip_height};

    // only meaningful once column and row are inside the clip window
    assign addr_sum = SUM_W'(r_iy[8:0]) * SUM_W'(lim_stride) + SUM_W'(r_ix[9:0]);

    assign clip = r_ix[15] | r_iy[15]
                | (r_ix >= {5'd0, lim_w})
                | (r_iy >= {6'd0, lim_h})
                | (addr_sum >= STORE_LIM);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func  <= i_func;
            r_ix    <= i_pixel_x[31:16];
            r_iy    <= i_pixel_y[31:16];
            r_depth <= i_pixel_depth;
            r_color <= i_pixel_color;
        end
        if (i_cmd.calc_addr) begin
            r_clip <= clip;
            r_addr <= addr_sum[ADDR_W-1:0];
        end
    end

    assign is_read    = r_func[1];
    assign color_only = (r_func == FUNC_COLOR_WRITE) | ~i_cfg.depth_enable;
    assign pass       = depth_pass(i_cfg.depth_mode, r_depth, r_rd_depth);

    assign wr_color = i_cmd.clr_en
                    | (i_cmd.finish & ~r_clip & ~is_read & (color_only | pass));
    assign wr_depth = i_cmd.clr_en
                    | (i_cmd.finish & ~r_clip & ~is_read & ~color_only & pass);

    // the clearing sweep shares the single write port
    assign wr_addr       = i_cmd.clr_en ? r_clr_cnt : r_addr;
    assign wr_color_data = i_cmd.clr_en ? 16'd0 : r_color;
    assign wr_depth_data = i_cmd.clr_en ? DEPTH_MIN : r_depth;

    always_ff @(posedge i_clk) begin
        if (wr_color) color_mem[wr_addr] <= wr_color_data;
        if (i_cmd.rd_en) r_rd_color <= color_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_depth) depth_mem[wr_addr] <= wr_depth_data;
        if (i_cmd.rd_en) r_rd_depth <= depth_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    assign o_sts.clr_done = (r_clr_cnt == LAST_ADDR);

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_read_color <= 16'd0;
            r_read_depth <= 32'd0;
            if (r_clip) begin
                r_status <= STAT_CLIPPED;
            end else if (is_read) begin
                r_status     <= STAT_DONE;
                r_read_color <= r_rd_color;
                r_read_depth <= r_rd_depth;
            end else if (!color_only && !pass) begin
                r_status <= STAT_REJECTED;
            end else begin
                r_status <= STAT_DONE;
            end
        end
    end

    assign o_status     = r_status;
    assign o_read_color = r_read_color;
    assign o_read_depth = r_read_depth;

endmodule

`default_nettype wire

@@ design/depth_tested_pixel_write_unit.sv @@
// depth_tested_pixel_write_unit: z-buffered pixel back end; each item goes
// through capture, address multiply and clip, store read, depth test and write.
// the result is registered in the depth test and write step, which waits for a
// free result slot; the next item may then be taken while that result waits.
// after reset a clearing sweep writes STORE_WORDS words, one per cycle, and no
// item is taken until it ends; configuration writes are taken throughout
`default_nettype none

module depth_tested_pixel_write_unit #(
    parameter int STORE_WORDS = 131072,
    parameter int MAX_ROW     = 512,
    parameter int MAX_LINES   = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    dtpw_in_if.sink                      i_pix,
    dtpw_out_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dtpw_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import dtpw_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    dtpw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dtpw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (i_pix.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dtpw_dp #(
        .STORE_WORDS (STORE_WORDS),
        .MAX_ROW     (MAX_ROW),
        .MAX_LINES   (MAX_LINES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_func        (i_pix.func),
        .i_pixel_x     (i_pix.pixel_x),
        .i_pixel_y     (i_pix.pixel_y),
        .i_pixel_depth (i_pix.pixel_depth),
        .i_pixel_color (i_pix.pixel_color),
        .o_status      (o_res.status),
        .o_read_color  (o_res.read_color),
        .o_read_depth  (o_res.read_depth)
    );

endmodule

`default_nettype wire
